// ===== design/pirsl_pkg.sv =====
// Shared types and constants for the sensor serial link master.
package pirsl_pkg;

   localparam int WRITE_BITS = 25;
   localparam int READ_BITS  = 40;
   localparam int TICK_W     = 12;
   localparam int BIT_W      = $clog2(READ_BITS + 1);
   localparam int POS_W      = $clog2(READ_BITS);
   localparam int CSR_IDX_W  = 3;

   localparam logic [TICK_W-1:0] RST_WRITE_BIT   = 12'd80;
   localparam logic [TICK_W-1:0] RST_WRITE_LATCH = 12'd2400;
   localparam logic [TICK_W-1:0] RST_READ_LEAD   = 12'd130;
   localparam logic [TICK_W-1:0] RST_READ_SAMPLE = 12'd5;
   localparam logic [TICK_W-1:0] RST_READ_TAIL   = 12'd14;
   localparam logic [TICK_W-1:0] RST_READ_END    = 12'd160;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WRITE_BIT   = 3'd0,
      CSR_WRITE_LATCH = 3'd1,
      CSR_READ_LEAD   = 3'd2,
      CSR_READ_SAMPLE = 3'd3,
      CSR_READ_TAIL   = 3'd4,
      CSR_READ_END    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2
   } command_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_W_LOW    = 4'd1,
      PH_W_HIGH   = 4'd2,
      PH_W_BIT    = 4'd3,
      PH_W_LATCH  = 4'd4,
      PH_R_LEAD   = 4'd5,
      PH_R_LOW    = 4'd6,
      PH_R_HIGH   = 4'd7,
      PH_R_SAMPLE = 4'd8,
      PH_R_TAIL   = 4'd9,
      PH_R_END    = 4'd10
   } phase_type;

   typedef struct packed {
      logic [TICK_W-1:0] write_bit_ticks;
      logic [TICK_W-1:0] write_latch_ticks;
      logic [TICK_W-1:0] read_lead_ticks;
      logic [TICK_W-1:0] read_sample_ticks;
      logic [TICK_W-1:0] read_tail_ticks;
      logic [TICK_W-1:0] read_end_ticks;
   } cfg_type;

   typedef struct packed {
      phase_type             phase;
      logic [BIT_W-1:0]      bit_index;
      logic [TICK_W-1:0]     tick_count;
      logic [READ_BITS-1:0]  shift_word;
   } seq_state_type;

   typedef struct packed {
      logic                  serial_out;
      logic                  line_drive;
      logic                  line_out;
      logic                  busy_res;
      logic                  write_done;
      logic                  read_valid;
      logic [READ_BITS-1:0]  read_word;
      logic                  start_ignored;
   } result_type;

endpackage

// ===== design/pirsl_csr.sv =====
// Timing configuration registers with a plain write port.
module pirsl_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [pirsl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pirsl_pkg::TICK_W-1:0]         csr_wdata,
   output pirsl_pkg::cfg_type                   cfg
);

   pirsl_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            pirsl_pkg::CSR_WRITE_BIT:   cfg_in.write_bit_ticks   = csr_wdata;
            pirsl_pkg::CSR_WRITE_LATCH: cfg_in.write_latch_ticks = csr_wdata;
            pirsl_pkg::CSR_READ_LEAD:   cfg_in.read_lead_ticks   = csr_wdata;
            pirsl_pkg::CSR_READ_SAMPLE: cfg_in.read_sample_ticks = csr_wdata;
            pirsl_pkg::CSR_READ_TAIL:   cfg_in.read_tail_ticks   = csr_wdata;
            pirsl_pkg::CSR_READ_END:    cfg_in.read_end_ticks    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.write_bit_ticks   <= pirsl_pkg::RST_WRITE_BIT;
         cfg_ff.write_latch_ticks <= pirsl_pkg::RST_WRITE_LATCH;
         cfg_ff.read_lead_ticks   <= pirsl_pkg::RST_READ_LEAD;
         cfg_ff.read_sample_ticks <= pirsl_pkg::RST_READ_SAMPLE;
         cfg_ff.read_tail_ticks   <= pirsl_pkg::RST_READ_TAIL;
         cfg_ff.read_end_ticks    <= pirsl_pkg::RST_READ_END;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/pirsl_seq.sv =====
// One-tick step of the write/read sequencer: next state and line outputs.
module pirsl_seq (
   input  pirsl_pkg::seq_state_type              state,
   input  pirsl_pkg::cfg_type                    cfg,
   input  logic [1:0]                            command,
   input  logic [pirsl_pkg::WRITE_BITS-1:0]      config_word,
   input  logic                                  line_level,
   output pirsl_pkg::seq_state_type              state_next,
   output pirsl_pkg::result_type                 result
);

   localparam logic [pirsl_pkg::BIT_W-1:0] WRITE_LAST =
      pirsl_pkg::BIT_W'(pirsl_pkg::WRITE_BITS - 1);
   localparam logic [pirsl_pkg::BIT_W-1:0] WRITE_CNT =
      pirsl_pkg::BIT_W'(pirsl_pkg::WRITE_BITS);
   localparam logic [pirsl_pkg::BIT_W-1:0] READ_CNT =
      pirsl_pkg::BIT_W'(pirsl_pkg::READ_BITS);

   function automatic logic [pirsl_pkg::TICK_W-1:0] min_one(
      input logic [pirsl_pkg::TICK_W-1:0] v);
      min_one = (v == '0) ? pirsl_pkg::TICK_W'(1) : v;
   endfunction

   function automatic logic [pirsl_pkg::TICK_W-1:0] step_len(
      input pirsl_pkg::phase_type p, input pirsl_pkg::cfg_type c);
      case (p)
         pirsl_pkg::PH_W_BIT:    step_len = min_one(c.write_bit_ticks);
         pirsl_pkg::PH_W_LATCH:  step_len = min_one(c.write_latch_ticks);
         pirsl_pkg::PH_R_LEAD:   step_len = c.read_lead_ticks;
         pirsl_pkg::PH_R_SAMPLE: step_len = min_one(c.read_sample_ticks);
         pirsl_pkg::PH_R_TAIL:   step_len = c.read_tail_ticks;
         pirsl_pkg::PH_R_END:    step_len = c.read_end_ticks;
         default:                step_len = pirsl_pkg::TICK_W'(1);
      endcase
   endfunction

   function automatic pirsl_pkg::phase_type follow(
      input pirsl_pkg::phase_type p, input logic [pirsl_pkg::BIT_W-1:0] b);
      case (p)
         pirsl_pkg::PH_W_LOW:    follow = pirsl_pkg::PH_W_HIGH;
         pirsl_pkg::PH_W_HIGH:   follow = pirsl_pkg::PH_W_BIT;
         pirsl_pkg::PH_W_BIT:    follow = (b < WRITE_CNT) ? pirsl_pkg::PH_W_LOW
                                                          : pirsl_pkg::PH_W_LATCH;
         pirsl_pkg::PH_R_LEAD:   follow = pirsl_pkg::PH_R_LOW;
         pirsl_pkg::PH_R_LOW:    follow = pirsl_pkg::PH_R_HIGH;
         pirsl_pkg::PH_R_HIGH:   follow = pirsl_pkg::PH_R_SAMPLE;
         pirsl_pkg::PH_R_SAMPLE: follow = pirsl_pkg::PH_R_TAIL;
         pirsl_pkg::PH_R_TAIL:   follow = (b < READ_CNT) ? pirsl_pkg::PH_R_LOW
                                                         : pirsl_pkg::PH_R_END;
         default:                follow = pirsl_pkg::PH_IDLE;
      endcase
   endfunction

   // zero-length steps are skipped; at most two in a row can be empty
   function automatic pirsl_pkg::phase_type enter(
      input pirsl_pkg::phase_type p, input logic [pirsl_pkg::BIT_W-1:0] b,
      input pirsl_pkg::cfg_type c);
      pirsl_pkg::phase_type q;
      q = p;
      for (int i = 0; i < 3; i++) begin
         if (q != pirsl_pkg::PH_IDLE && step_len(q, c) == '0) begin
            q = follow(q, b);
         end
      end
      enter = q;
   endfunction

   pirsl_pkg::seq_state_type s;
   pirsl_pkg::phase_type     p;
   logic [pirsl_pkg::TICK_W:0] tick_inc;
   logic [pirsl_pkg::POS_W-1:0] wr_pos;

   always_comb begin
      s = state;
      result = '0;
      if (command == pirsl_pkg::CMD_WRITE || command == pirsl_pkg::CMD_READ) begin
         if (state.phase != pirsl_pkg::PH_IDLE) begin
            result.start_ignored = 1'b1;
         end else begin
            s.bit_index  = '0;
            s.tick_count = '0;
            if (command == pirsl_pkg::CMD_WRITE) begin
               s.shift_word = pirsl_pkg::READ_BITS'(config_word);
               s.phase      = pirsl_pkg::PH_W_LOW;
            end else begin
               s.shift_word = '0;
               s.phase      = enter(pirsl_pkg::PH_R_LEAD, '0, cfg);
            end
         end
      end

      p        = s.phase;
      wr_pos   = pirsl_pkg::POS_W'(WRITE_LAST - s.bit_index);
      tick_inc = {1'b0, s.tick_count} + 1'b1;

      if (p != pirsl_pkg::PH_IDLE) begin
         result.busy_res = 1'b1;
         case (p)
            pirsl_pkg::PH_W_LOW:   result.line_drive = 1'b1;
            pirsl_pkg::PH_W_HIGH: begin
               result.line_drive = 1'b1;
               result.serial_out = 1'b1;
            end
            pirsl_pkg::PH_W_BIT: begin
               result.line_drive = 1'b1;
               if (s.bit_index < WRITE_CNT) begin
                  result.serial_out = s.shift_word[wr_pos];
               end
            end
            pirsl_pkg::PH_W_LATCH: result.line_drive = 1'b1;
            pirsl_pkg::PH_R_LOW:   result.line_drive = 1'b1;
            pirsl_pkg::PH_R_HIGH: begin
               result.line_drive = 1'b1;
               result.line_out   = 1'b1;
            end
            pirsl_pkg::PH_R_END:   result.line_drive = 1'b1;
            default: ;
         endcase

         s.tick_count = tick_inc[pirsl_pkg::TICK_W-1:0];
         if (tick_inc >= {1'b0, step_len(p, cfg)}) begin
            s.tick_count = '0;
            if (p == pirsl_pkg::PH_W_BIT) begin
               s.bit_index = s.bit_index + 1'b1;
            end
            if (p == pirsl_pkg::PH_R_SAMPLE) begin
               s.shift_word = {s.shift_word[pirsl_pkg::READ_BITS-2:0], line_level};
               s.bit_index  = s.bit_index + 1'b1;
            end
            s.phase = enter(follow(p, s.bit_index), s.bit_index, cfg);
            if (s.phase == pirsl_pkg::PH_IDLE) begin
               s.bit_index = '0;
               if (p <= pirsl_pkg::PH_W_LATCH) begin
                  result.write_done = 1'b1;
               end else begin
                  result.read_valid = 1'b1;
                  result.read_word  = s.shift_word;
               end
            end
         end
      end
      state_next = s;
   end

endmodule

// ===== design/pir_sensor_serial_link_master_core.sv =====
// Top level of the sensor serial link master: handshake, state and result registers.
// Each accepted tick is evaluated combinationally; its result transfer is offered the next cycle.
// Throughput: 1 tick per cycle while rsp_ready is high; req_ready drops while a result waits unaccepted.
// A result waiting in the output register does not block a new request once rsp_ready is high.
// Reset (synchronous): sequencer idle, counters and shift word cleared, timing registers
// back to their defaults, no response pending.
module pir_sensor_serial_link_master_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_command,
   input  logic [pirsl_pkg::WRITE_BITS-1:0]     req_config_word,
   input  logic                                 req_line_level,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_serial_out,
   output logic                                 rsp_line_drive,
   output logic                                 rsp_line_out,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_write_done,
   output logic                                 rsp_read_valid,
   output logic [pirsl_pkg::READ_BITS-1:0]      rsp_read_word,
   output logic                                 rsp_start_ignored,
   input  logic                                 csr_wr_en,
   input  logic [pirsl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pirsl_pkg::TICK_W-1:0]         csr_wdata
);

   pirsl_pkg::cfg_type       cfg;
   pirsl_pkg::seq_state_type state_ff, state_in;
   pirsl_pkg::result_type    result_ff, result_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     req_xfer;

   pirsl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pirsl_seq u_seq (
      .state       (state_ff),
      .cfg         (cfg),
      .command     (req_command),
      .config_word (req_config_word),
      .line_level  (req_line_level),
      .state_next  (state_in),
      .result      (result_in)
   );

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_xfer     = req_valid && req_ready;
   assign rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= pirsl_pkg::PH_IDLE;
         state_ff.bit_index  <= '0;
         state_ff.tick_count <= '0;
         state_ff.shift_word <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_serial_out    = result_ff.serial_out;
   assign rsp_line_drive    = result_ff.line_drive;
   assign rsp_line_out      = result_ff.line_out;
   assign rsp_busy_res      = result_ff.busy_res;
   assign rsp_write_done    = result_ff.write_done;
   assign rsp_read_valid    = result_ff.read_valid;
   assign rsp_read_word     = result_ff.read_word;
   assign rsp_start_ignored = result_ff.start_ignored;

endmodule

// ===== sim/pirsl_link_checker.sv =====
// Checker for the sensor link master: predicts every tick's outputs and compares each response.
module pirsl_link_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [1:0]                        req_command,
   input  logic [pirsl_pkg::WRITE_BITS-1:0]  req_config_word,
   input  logic                              req_line_level,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_serial_out,
   input  logic                              rsp_line_drive,
   input  logic                              rsp_line_out,
   input  logic                              rsp_busy_res,
   input  logic                              rsp_write_done,
   input  logic                              rsp_read_valid,
   input  logic [pirsl_pkg::READ_BITS-1:0]   rsp_read_word,
   input  logic                              rsp_start_ignored,
   input  logic                              csr_wr_en,
   input  logic [pirsl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pirsl_pkg::TICK_W-1:0]      csr_wdata,
   output int unsigned                       failures,
   output int unsigned                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import pirsl_pkg::*;

   cfg_type              timing;
   phase_type            seq_phase;
   int unsigned          seq_bit;
   int unsigned          seq_ticks;
   logic [READ_BITS-1:0] seq_shift;
   result_type           link_outputs_due[$];
   int unsigned          mismatch_total = 0;
   int unsigned          rsp_seen = 0;

   function automatic int unsigned span_floor(logic [TICK_W-1:0] v);
      return (v == '0) ? 32'd1 : 32'(v);
   endfunction

   function automatic int unsigned phase_span(phase_type p);
      case (p)
         PH_W_BIT:    return span_floor(timing.write_bit_ticks);
         PH_W_LATCH:  return span_floor(timing.write_latch_ticks);
         PH_R_LEAD:   return 32'(timing.read_lead_ticks);
         PH_R_SAMPLE: return span_floor(timing.read_sample_ticks);
         PH_R_TAIL:   return 32'(timing.read_tail_ticks);
         PH_R_END:    return 32'(timing.read_end_ticks);
         default:     return 1;
      endcase
   endfunction

   function automatic phase_type phase_after(phase_type p);
      case (p)
         PH_W_LOW:    return PH_W_HIGH;
         PH_W_HIGH:   return PH_W_BIT;
         PH_W_BIT:    return (seq_bit < WRITE_BITS) ? PH_W_LOW : PH_W_LATCH;
         PH_R_LEAD:   return PH_R_LOW;
         PH_R_LOW:    return PH_R_HIGH;
         PH_R_HIGH:   return PH_R_SAMPLE;
         PH_R_SAMPLE: return PH_R_TAIL;
         PH_R_TAIL:   return (seq_bit < READ_BITS) ? PH_R_LOW : PH_R_END;
         default:     return PH_IDLE;
      endcase
   endfunction

   // zero-length steps are skipped on entry
   function automatic phase_type first_live_phase(phase_type p);
      phase_type q;
      q = p;
      while (q != PH_IDLE && phase_span(q) == 0)
         q = phase_after(q);
      return q;
   endfunction

   function automatic result_type predict_link_tick(logic [1:0] cmd,
                                                    logic [WRITE_BITS-1:0] word,
                                                    logic level);
      result_type r;
      phase_type  p;
      r = '0;
      if (cmd == CMD_WRITE || cmd == CMD_READ) begin
         if (seq_phase != PH_IDLE) begin
            r.start_ignored = 1'b1;
         end else begin
            seq_bit   = 0;
            seq_ticks = 0;
            seq_shift = '0;
            if (cmd == CMD_WRITE) begin
               seq_shift[WRITE_BITS-1:0] = word;
               seq_phase = first_live_phase(PH_W_LOW);
            end else begin
               seq_phase = first_live_phase(PH_R_LEAD);
            end
         end
      end
      if (seq_phase != PH_IDLE) begin
         p = seq_phase;
         r.busy_res = 1'b1;
         case (p)
            PH_W_LOW:   r.line_drive = 1'b1;
            PH_W_HIGH: begin
               r.line_drive = 1'b1;
               r.serial_out = 1'b1;
            end
            PH_W_BIT: begin
               r.line_drive = 1'b1;
               if (seq_bit < WRITE_BITS)
                  r.serial_out = seq_shift[WRITE_BITS-1-seq_bit];
            end
            PH_W_LATCH: r.line_drive = 1'b1;
            PH_R_LOW:   r.line_drive = 1'b1;
            PH_R_HIGH: begin
               r.line_drive = 1'b1;
               r.line_out   = 1'b1;
            end
            PH_R_END:   r.line_drive = 1'b1;
            default: ;
         endcase
         seq_ticks++;
         if (seq_ticks >= phase_span(p)) begin
            seq_ticks = 0;
            if (p == PH_W_BIT)
               seq_bit++;
            if (p == PH_R_SAMPLE) begin
               seq_shift = {seq_shift[READ_BITS-2:0], level};
               seq_bit++;
            end
            seq_phase = first_live_phase(phase_after(p));
            if (seq_phase == PH_IDLE) begin
               seq_bit = 0;
               if (p <= PH_W_LATCH) begin
                  r.write_done = 1'b1;
               end else begin
                  r.read_valid = 1'b1;
                  r.read_word  = seq_shift;
               end
            end
         end
      end
      return r;
   endfunction

   task automatic report_failure(input string msg);
      $display("checker: %s", msg);
      mismatch_total++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want)
         report_failure($sformatf("response %0d: %s is %0h, predicted %0h",
                                  rsp_seen, name, got, want));
   endtask

   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         timing.write_bit_ticks   = RST_WRITE_BIT;
         timing.write_latch_ticks = RST_WRITE_LATCH;
         timing.read_lead_ticks   = RST_READ_LEAD;
         timing.read_sample_ticks = RST_READ_SAMPLE;
         timing.read_tail_ticks   = RST_READ_TAIL;
         timing.read_end_ticks    = RST_READ_END;
         seq_phase = PH_IDLE;
         seq_bit   = 0;
         seq_ticks = 0;
         seq_shift = '0;
         link_outputs_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (link_outputs_due.size() == 0) begin
               report_failure($sformatf("response %0d arrived with no tick outstanding",
                                        rsp_seen));
            end else begin
               want = link_outputs_due.pop_front();
               compare_field("serial_out", 64'(rsp_serial_out), 64'(want.serial_out));
               compare_field("line_drive", 64'(rsp_line_drive), 64'(want.line_drive));
               compare_field("line_out", 64'(rsp_line_out), 64'(want.line_out));
               compare_field("busy_res", 64'(rsp_busy_res), 64'(want.busy_res));
               compare_field("write_done", 64'(rsp_write_done), 64'(want.write_done));
               compare_field("read_valid", 64'(rsp_read_valid), 64'(want.read_valid));
               compare_field("read_word", 64'(rsp_read_word), 64'(want.read_word));
               compare_field("start_ignored", 64'(rsp_start_ignored),
                             64'(want.start_ignored));
            end
            rsp_seen++;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WRITE_BIT:   timing.write_bit_ticks   = csr_wdata;
               CSR_WRITE_LATCH: timing.write_latch_ticks = csr_wdata;
               CSR_READ_LEAD:   timing.read_lead_ticks   = csr_wdata;
               CSR_READ_SAMPLE: timing.read_sample_ticks = csr_wdata;
               CSR_READ_TAIL:   timing.read_tail_ticks   = csr_wdata;
               CSR_READ_END:    timing.read_end_ticks    = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            link_outputs_due.push_back(predict_link_tick(req_command, req_config_word,
                                                         req_line_level));
      end
      failures <= mismatch_total;
      pending  <= link_outputs_due.size();
   end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the sensor link master: clock, reset, tick stimulus, timing setups, verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pirsl_pkg::*;

   localparam logic [1:0]           CMD_SPARE       = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI    = 3'd7;
   localparam int                   LVL_RANDOM      = 0;
   localparam int                   LVL_ONES        = 1;
   localparam int                   LVL_ZEROS       = 2;
   localparam int unsigned          HOLD_OFF_CYCLES = 400;
   localparam int unsigned          CYCLE_LIMIT     = 100_000;
   localparam int unsigned          DEF_WRITE_TICKS = 160;
   localparam int unsigned          DEF_READ_TICKS  = 175;
   localparam int unsigned          RANDOM_ITEMS    = 95;

   logic                  clock;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_command     = CMD_TICK;
   logic [WRITE_BITS-1:0] req_config_word = '0;
   logic                  req_line_level  = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic                  rsp_serial_out;
   logic                  rsp_line_drive;
   logic                  rsp_line_out;
   logic                  rsp_busy_res;
   logic                  rsp_write_done;
   logic                  rsp_read_valid;
   logic [READ_BITS-1:0]  rsp_read_word;
   logic                  rsp_start_ignored;
   logic                  csr_wr_en       = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [TICK_W-1:0]     csr_wdata       = '0;
   logic                  hold_off_req    = 1'b0;
   int unsigned           failures;
   int unsigned           pending;

   cfg_type     link_timing;
   int unsigned busy_left     = 0;
   bit          steady_feed   = 1'b0;
   bit          sender_idles  = 1'b0;
   int unsigned sender_burst  = 0;
   int unsigned items_sent    = 0;
   int unsigned writes_begun  = 0;
   int unsigned reads_begun   = 0;
   int unsigned settings_used = 1;
   int unsigned seqs_closed   = 0;

   pir_sensor_serial_link_master_core i_dut (.*);

   pirsl_link_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin : completions
      if (rsp_valid && rsp_ready && (rsp_write_done || rsp_read_valid))
         seqs_closed++;
   end

   function automatic int unsigned gap_length();
      if ($urandom_range(0, 9) < 9)
         return $urandom_range(1, 3);
      return $urandom_range(12, 48);
   endfunction

   function automatic logic [WRITE_BITS-1:0] rand_word();
      logic [WRITE_BITS-1:0] w;
      w = WRITE_BITS'($urandom());
      return w;
   endfunction

   function automatic logic pick_level(int mode);
      case (mode)
         LVL_ONES:  return 1'b1;
         LVL_ZEROS: return 1'b0;
         default:   return 1'($urandom_range(0, 1));
      endcase
   endfunction

   function automatic logic [TICK_W-1:0] short_ticks();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 6)
         return TICK_W'($urandom_range(0, 2));
      if (roll < 9)
         return TICK_W'($urandom_range(3, 8));
      return TICK_W'($urandom_range(9, 30));
   endfunction

   function automatic cfg_type random_timing();
      cfg_type t;
      t.write_bit_ticks   = short_ticks();
      t.write_latch_ticks = short_ticks();
      t.read_lead_ticks   = short_ticks();
      t.read_sample_ticks = short_ticks();
      t.read_tail_ticks   = short_ticks();
      t.read_end_ticks    = short_ticks();
      return t;
   endfunction

   function automatic cfg_type default_timing();
      cfg_type t;
      t.write_bit_ticks   = RST_WRITE_BIT;
      t.write_latch_ticks = RST_WRITE_LATCH;
      t.read_lead_ticks   = RST_READ_LEAD;
      t.read_sample_ticks = RST_READ_SAMPLE;
      t.read_tail_ticks   = RST_READ_TAIL;
      t.read_end_ticks    = RST_READ_END;
      return t;
   endfunction

   // ticks from an accepted start to its completion tick, inclusive
   function automatic int unsigned sequence_ticks(logic [1:0] cmd);
      int unsigned bit_len, latch_len, sample_len;
      bit_len    = (link_timing.write_bit_ticks == 0) ? 1 : link_timing.write_bit_ticks;
      latch_len  = (link_timing.write_latch_ticks == 0) ? 1 : link_timing.write_latch_ticks;
      sample_len = (link_timing.read_sample_ticks == 0) ? 1 : link_timing.read_sample_ticks;
      if (cmd == CMD_WRITE)
         return WRITE_BITS * (2 + bit_len) + latch_len;
      return link_timing.read_lead_ticks + link_timing.read_end_ticks
             + READ_BITS * (2 + sample_len + link_timing.read_tail_ticks);
   endfunction

   task automatic send_item(input logic [1:0] cmd, input logic [WRITE_BITS-1:0] word,
                            input logic level);
      int unsigned gap;
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_config_word <= word;
      req_line_level  <= level;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (busy_left == 0 && (cmd == CMD_WRITE || cmd == CMD_READ)) begin
         busy_left = sequence_ticks(cmd);
         if (cmd == CMD_WRITE)
            writes_begun++;
         else
            reads_begun++;
      end
      if (busy_left != 0)
         busy_left--;
      if (!steady_feed) begin
         if (sender_burst == 0) begin
            sender_burst = $urandom_range(20, 150);
            sender_idles = ($urandom_range(0, 2) != 0);
         end
         sender_burst--;
         if (sender_idles && $urandom_range(0, 99) < 25) begin
            gap = gap_length();
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_ticks(input int unsigned count, input int mode);
      for (int unsigned i = 0; i < count; i++)
         send_item(CMD_TICK, rand_word(), pick_level(mode));
   endtask

   task automatic drain_sequence(input int mode);
      while (busy_left != 0)
         send_item(CMD_TICK, rand_word(), pick_level(mode));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // plain ticks until the running sequence reports its completion
   task automatic finish_sequence(input int mode);
      int unsigned goal;
      goal = seqs_closed + 1;
      while (seqs_closed < goal)
         send_item(CMD_TICK, rand_word(), pick_level(mode));
      settle();
      busy_left = 0;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_WRITE_BIT:   link_timing.write_bit_ticks   = data;
         CSR_WRITE_LATCH: link_timing.write_latch_ticks = data;
         CSR_READ_LEAD:   link_timing.read_lead_ticks   = data;
         CSR_READ_SAMPLE: link_timing.read_sample_ticks = data;
         CSR_READ_TAIL:   link_timing.read_tail_ticks   = data;
         CSR_READ_END:    link_timing.read_end_ticks    = data;
         default: ;
      endcase
   endtask

   task automatic load_timing(input cfg_type t);
      write_csr(CSR_WRITE_BIT, t.write_bit_ticks);
      write_csr(CSR_WRITE_LATCH, t.write_latch_ticks);
      write_csr(CSR_READ_LEAD, t.read_lead_ticks);
      write_csr(CSR_READ_SAMPLE, t.read_sample_ticks);
      write_csr(CSR_READ_TAIL, t.read_tail_ticks);
      write_csr(CSR_READ_END, t.read_end_ticks);
      settings_used++;
   endtask

   // mostly complete write/read sequences; stray starts and spare commands mixed in
   task automatic random_phase(input int unsigned count, input bit with_hold);
      int unsigned done, roll;
      int          level_mode;
      logic [1:0]  cmd;
      logic [WRITE_BITS-1:0] word;
      cfg_type     fast;
      done       = 0;
      level_mode = LVL_RANDOM;
      fast       = '0;
      while (done < count) begin
         roll = $urandom_range(0, 99);
         word = rand_word();
         if (busy_left == 0) begin
            if (roll < 5)
               cmd = CMD_SPARE;
            else if (roll < 30)
               cmd = CMD_TICK;
            else if (roll < 65)
               cmd = CMD_WRITE;
            else
               cmd = CMD_READ;
            if (cmd == CMD_WRITE) begin
               roll = $urandom_range(0, 9);
               if (roll == 0)
                  word = '1;
               else if (roll == 1)
                  word = '0;
            end
            if (cmd == CMD_READ) begin
               roll = $urandom_range(0, 9);
               level_mode = (roll == 0) ? LVL_ONES : (roll == 1) ? LVL_ZEROS : LVL_RANDOM;
            end
         end else begin
            if (roll < 4)
               cmd = CMD_SPARE;
            else if (roll < 9)
               cmd = (roll % 2) ? CMD_WRITE : CMD_READ;
            else
               cmd = CMD_TICK;
         end
         send_item(cmd, word, pick_level(level_mode));
         done++;
         if (with_hold && done == count / 2)
            hold_off_req <= 1'b1;
      end
      settle();
      // a sequence still running is cut short with the shortest lengths
      if (busy_left != 0) begin
         load_timing(fast);
         finish_sequence(level_mode);
      end
   endtask

   initial begin : receiver
      int unsigned run_left, stall_left;
      bit          stalls;
      run_left   = 0;
      stall_left = 0;
      stalls     = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req <= 1'b0;
            rsp_ready    <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if (run_left == 0) begin
               run_left = $urandom_range(16, 160);
               stalls   = ($urandom_range(0, 2) != 0);
            end
            run_left--;
            if (stall_left != 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else if (stalls && $urandom_range(0, 99) < 20) begin
               stall_left = gap_length() - 1;
               rsp_ready  <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
         @(posedge clock);
      $display("tb: done, errors");
      $finish;
   end

   initial begin : stimulus
      cfg_type     t;
      int unsigned k;
      link_timing = default_timing();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset timing: idle ticks, spare command, a write with stray starts, then a read;
      // each is cut short by shortening its lengths mid-step
      send_item(CMD_TICK, '0, 1'b0);
      send_item(CMD_TICK, '1, 1'b1);
      send_item(CMD_SPARE, rand_word(), 1'b1);
      send_item(CMD_WRITE, 25'h1A5A5A5, 1'b0);
      send_item(CMD_READ, rand_word(), 1'b1);
      send_item(CMD_WRITE, '0, 1'b0);
      send_item(CMD_SPARE, rand_word(), 1'b0);
      send_ticks(DEF_WRITE_TICKS, LVL_RANDOM);
      settle();
      t = '0;
      load_timing(t);
      finish_sequence(LVL_RANDOM);
      load_timing(default_timing());
      send_item(CMD_READ, rand_word(), 1'b1);
      send_ticks(DEF_READ_TICKS, LVL_RANDOM);
      settle();
      load_timing(t);
      finish_sequence(LVL_RANDOM);

      // all lengths zero; spare register indexes must be ignored
      write_csr(CSR_SPARE_LO, '1);
      write_csr(CSR_SPARE_HI, 12'hA5C);
      send_item(CMD_WRITE, '1, 1'b0);
      drain_sequence(LVL_RANDOM);
      send_item(CMD_READ, rand_word(), 1'b1);
      drain_sequence(LVL_ONES);
      settle();

      // full-scale bit, latch, lead and end steps, shortened while running
      steady_feed = 1'b1;
      t = '0;
      t.write_bit_ticks   = '1;
      t.write_latch_ticks = '1;
      t.read_lead_ticks   = '1;
      t.read_end_ticks    = '1;
      load_timing(t);
      send_item(CMD_WRITE, rand_word(), 1'b0);
      send_ticks(6, LVL_RANDOM);
      settle();
      write_csr(CSR_WRITE_BIT, '0);
      send_ticks(90, LVL_RANDOM);
      settle();
      write_csr(CSR_WRITE_LATCH, 12'd2);
      finish_sequence(LVL_RANDOM);
      send_item(CMD_READ, rand_word(), 1'b0);
      send_ticks(8, LVL_RANDOM);
      settle();
      write_csr(CSR_READ_LEAD, '0);
      send_ticks(130, LVL_RANDOM);
      settle();
      write_csr(CSR_READ_END, 12'd4);
      finish_sequence(LVL_RANDOM);
      steady_feed = 1'b0;

      for (k = 0; k < 4; k++) begin
         load_timing(random_timing());
         if ($urandom_range(0, 2) == 0)
            write_csr(($urandom_range(0, 1) != 0) ? CSR_SPARE_HI : CSR_SPARE_LO,
                      TICK_W'($urandom_range(0, 4095)));
         random_phase(RANDOM_ITEMS, k == 1);
      end
      settle();
      repeat (4) @(posedge clock);

      $display("tb: %0d ticks under %0d timing setups, %0d writes and %0d reads started",
               items_sent, settings_used, writes_begun, reads_begun);
      $display("tb: covered zero and full-scale lengths, lengths cut mid-step, stray starts,");
      $display("tb: and a %0d-cycle receiver stall", HOLD_OFF_CYCLES);
      if (failures == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
